/* rtl/core/gcdl_pkg.sv */
// Shared types and constants for the gcd/lcm unit.
// Depends on nothing; imported by gcdl_sub, gcdl_core and gcd_lcm_unit.
`default_nettype none
package gcdl_pkg;

    localparam int DATA_BITS = 31;
    localparam int WIDE_BITS = 2 * DATA_BITS;
    localparam int CNT_BITS  = $clog2(DATA_BITS);

    // One request: two operands
    typedef struct packed {
        logic [DATA_BITS-1:0] operand_a;
        logic [DATA_BITS-1:0] operand_b;
    } in_t;

    // One result
    typedef struct packed {
        logic [DATA_BITS-1:0] gcd_value;
        logic                 coprime;
        logic [WIDE_BITS-1:0] lcm_value;
        logic                 lcm_error;
    } out_t;

    // Sequencer status toward the top level
    typedef struct packed {
        logic idle;
        logic done;
    } core_status_t;

endpackage
`default_nettype wire

/* rtl/core/gcdl_sub.sv */
// Shared subtract/compare unit used by both the gcd loop and the divider.
// Depends on gcdl_pkg.
`default_nettype none
module gcdl_sub (
    input  wire logic [gcdl_pkg::DATA_BITS:0] lhs,
    input  wire logic [gcdl_pkg::DATA_BITS:0] rhs,
    output logic      [gcdl_pkg::DATA_BITS:0] diff,
    output logic                              borrow
);
    import gcdl_pkg::*;

    logic [DATA_BITS+1:0] full;

    // One extra bit catches the borrow (lhs < rhs)
    assign full   = {1'b0, lhs} - {1'b0, rhs};
    assign diff   = full[DATA_BITS:0];
    assign borrow = full[DATA_BITS+1];

endmodule
`default_nettype wire

/* rtl/core/gcdl_core.sv */
// Sequencer and datapath: binary gcd, restoring divide a/gcd, one multiply.
// Depends on gcdl_pkg and gcdl_sub.
`default_nettype none
module gcdl_core (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire gcdl_pkg::in_t         req,
    input  wire logic                  res_take,
    output gcdl_pkg::core_status_t     status,
    output gcdl_pkg::out_t             res
);
    import gcdl_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD,
        ST_DIV,
        ST_MUL,
        ST_DONE
    } state_t;

    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(DATA_BITS - 1);

    state_t               state_reg, state_next;
    logic [DATA_BITS-1:0] x_reg, x_next;
    logic [DATA_BITS-1:0] y_reg, y_next;
    logic [CNT_BITS-1:0]  k_reg, k_next;
    logic [DATA_BITS-1:0] b_reg, b_next;
    logic [DATA_BITS-1:0] g_reg, g_next;
    logic [DATA_BITS-1:0] rem_reg, rem_next;
    logic [DATA_BITS-1:0] dq_reg, dq_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [WIDE_BITS-1:0] prod_reg, prod_next;
    logic                 err_reg, err_next;

    logic [DATA_BITS:0]   sub_lhs, sub_rhs, sub_diff;
    logic                 sub_borrow;
    logic [DATA_BITS:0]   rem_shift;
    logic [DATA_BITS-1:0] gcd_shifted;

    // Subtractor input select: divider step or gcd compare
    assign rem_shift = {rem_reg, dq_reg[DATA_BITS-1]};
    always_comb
    begin
        if (state_reg == ST_DIV)
        begin
            sub_lhs = rem_shift;
            sub_rhs = {1'b0, g_reg};
        end
        else
        begin
            sub_lhs = {1'b0, x_reg};
            sub_rhs = {1'b0, y_reg};
        end
    end

    gcdl_sub u_sub (
        .lhs    (sub_lhs),
        .rhs    (sub_rhs),
        .diff   (sub_diff),
        .borrow (sub_borrow)
    );

    // Final gcd: surviving operand times the common power of two
    assign gcd_shifted = (x_reg | y_reg) << k_reg;

    // Next-state and datapath logic
    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        k_next     = k_reg;
        b_next     = b_reg;
        g_next     = g_reg;
        rem_next   = rem_reg;
        dq_next    = dq_reg;
        cnt_next   = cnt_reg;
        prod_next  = prod_reg;
        err_next   = err_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    x_next     = req.operand_a;
                    y_next     = req.operand_b;
                    dq_next    = req.operand_a;
                    b_next     = req.operand_b;
                    k_next     = '0;
                    state_next = ST_GCD;
                end
            end
            ST_GCD:
            begin
                if ((x_reg == '0) || (y_reg == '0))
                begin
                    g_next   = gcd_shifted;
                    rem_next = '0;
                    cnt_next = '0;
                    if (gcd_shifted == '0)
                    begin
                        // both operands zero: lcm undefined
                        err_next   = 1'b1;
                        prod_next  = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        err_next   = 1'b0;
                        state_next = ST_DIV;
                    end
                end
                else if (!x_reg[0] && !y_reg[0])
                begin
                    x_next = x_reg >> 1;
                    y_next = y_reg >> 1;
                    k_next = k_reg + 1'b1;
                end
                else if (!x_reg[0])
                begin
                    x_next = x_reg >> 1;
                end
                else if (!y_reg[0])
                begin
                    y_next = y_reg >> 1;
                end
                else if (sub_borrow)
                begin
                    // keep the larger value in x
                    x_next = y_reg;
                    y_next = x_reg;
                end
                else
                begin
                    x_next = sub_diff[DATA_BITS-1:0];
                end
            end
            ST_DIV:
            begin
                // restoring divide, one quotient bit per cycle
                if (sub_borrow)
                begin
                    rem_next = rem_shift[DATA_BITS-1:0];
                end
                else
                begin
                    rem_next = sub_diff[DATA_BITS-1:0];
                end
                dq_next  = {dq_reg[DATA_BITS-2:0], ~sub_borrow};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = WIDE_BITS'(dq_reg) * WIDE_BITS'(b_reg);
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            x_reg     <= '0;
            y_reg     <= '0;
            k_reg     <= '0;
            b_reg     <= '0;
            g_reg     <= '0;
            rem_reg   <= '0;
            dq_reg    <= '0;
            cnt_reg   <= '0;
            prod_reg  <= '0;
            err_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            k_reg     <= k_next;
            b_reg     <= b_next;
            g_reg     <= g_next;
            rem_reg   <= rem_next;
            dq_reg    <= dq_next;
            cnt_reg   <= cnt_next;
            prod_reg  <= prod_next;
            err_reg   <= err_next;
        end
    end

    // Status and result
    assign status.idle   = (state_reg == ST_IDLE);
    assign status.done   = (state_reg == ST_DONE);
    assign res.gcd_value = g_reg;
    assign res.coprime   = (g_reg == DATA_BITS'(1));
    assign res.lcm_value = prod_reg;
    assign res.lcm_error = err_reg;

endmodule
`default_nettype wire

/* rtl/core/gcd_lcm_unit.sv */
// gcd_lcm_unit: gcd, coprime flag and double-width lcm; uses gcdl_pkg, gcdl_core, gcdl_sub.
// The binary gcd loop takes one shift, swap or subtract per cycle, then a restoring divide
// gives a/gcd and one multiply gives the lcm; both operands zero skip divide and multiply.
// The sequencer works on one request at a time; in_ready is high only while idle, and a
// result stalled in the output register holds the sequencer until it drains.
// Reset (rst_n, async, active low) empties the sequencer and the output register.
`default_nettype none
module gcd_lcm_unit (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire gcdl_pkg::in_t  in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output gcdl_pkg::out_t      out_data
);
    import gcdl_pkg::*;

    core_status_t status;
    out_t         res;
    logic         res_take;
    logic         out_valid_reg, out_valid_next;
    out_t         out_data_reg, out_data_next;

    assign in_ready = status.idle;

    // Result moves to the output register once it is free or being drained
    assign res_take = status.done && (!out_valid_reg || out_ready);

    gcdl_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_valid && in_ready),
        .req      (in_data),
        .res_take (res_take),
        .status   (status),
        .res      (res)
    );

    // Output register next values
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Checks
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("sequencer still idle after accepting a request");

    a_coprime_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.coprime) |-> (out_data.gcd_value == DATA_BITS'(1)))
        else $error("coprime flag set with gcd other than one");

    a_error_iff_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.lcm_error == (out_data.gcd_value == '0)))
        else $error("lcm error flag disagrees with zero gcd");

    a_error_lcm_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.lcm_error) |-> (out_data.lcm_value == '0))
        else $error("lcm not zero on error");

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for gcd_lcm_unit: gcd, coprime flag and double-width lcm.
// Depends on gcdl_pkg (request and result structs) and the gcd_lcm_unit RTL.
module tb;

    import gcdl_pkg::*;

    localparam logic [DATA_BITS-1:0] OPERAND_MAX   = {DATA_BITS{1'b1}};
    localparam int unsigned          RANDOM_ITEMS  = 1880;
    localparam int unsigned          PHASE_COUNT   = 4;
    localparam int unsigned          DRAIN_CYCLES  = 256;
    localparam int unsigned          CYCLE_LIMIT   = 2_500_000;
    localparam int unsigned          REPORT_LIMIT  = 10;

    // Expected gcd/lcm results, oldest first, with the mismatch tally
    class gcd_lcm_scoreboard;
        out_t        expected_q[$];
        int unsigned error_count;

        function new();
            error_count = 0;
        endfunction

        // Euclid's remainder loop, then lcm as (a / gcd) * b at double width
        function out_t predict_gcd_lcm(in_t req);
            logic [WIDE_BITS-1:0] x;
            logic [WIDE_BITS-1:0] y;
            logic [WIDE_BITS-1:0] r;
            logic [WIDE_BITS-1:0] wide_a;
            logic [WIDE_BITS-1:0] wide_b;
            out_t                 res;
            wide_a = WIDE_BITS'(req.operand_a);
            wide_b = WIDE_BITS'(req.operand_b);
            x = wide_a;
            y = wide_b;
            while (y != 0)
            begin
                r = x % y;
                x = y;
                y = r;
            end
            res.gcd_value = x[DATA_BITS-1:0];
            res.coprime   = (x == 1);
            res.lcm_error = (x == 0);
            res.lcm_value = (x == 0) ? '0 : (wide_a / x) * wide_b;
            return res;
        endfunction

        function void note_request(in_t req);
            expected_q.push_back(predict_gcd_lcm(req));
        endfunction

        function void check_result(out_t got);
            out_t want;
            if (expected_q.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("[%0t] unexpected result: gcd=%0d coprime=%0d lcm=%0d err=%0d",
                             $time, got.gcd_value, got.coprime, got.lcm_value, got.lcm_error);
                return;
            end
            want = expected_q.pop_front();
            if (got.gcd_value !== want.gcd_value || got.coprime !== want.coprime ||
                got.lcm_value !== want.lcm_value || got.lcm_error !== want.lcm_error)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                begin
                    $display("[%0t] result mismatch", $time);
                    $display("    expected gcd=%0d coprime=%0d lcm=%0d err=%0d",
                             want.gcd_value, want.coprime, want.lcm_value, want.lcm_error);
                    $display("    actual   gcd=%0d coprime=%0d lcm=%0d err=%0d",
                             got.gcd_value, got.coprime, got.lcm_value, got.lcm_error);
                end
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    in_t         in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_t        out_data;

    int unsigned       send_idle_pct = 0;
    int unsigned       recv_stall_pct = 0;
    int unsigned       cycle_count = 0;
    gcd_lcm_scoreboard results;

    gcd_lcm_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Result side: check on handshake, then pick next cycle's ready
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            results.check_result(out_data);
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    function automatic in_t pack_request(logic [DATA_BITS-1:0] a, logic [DATA_BITS-1:0] b);
        in_t req;
        req.operand_a = a;
        req.operand_b = b;
        return req;
    endfunction

    // Random operand pairs, weighted toward shared factors and slow Euclid chains
    function automatic in_t make_random_request();
        int unsigned     pick;
        int unsigned     gbits;
        int unsigned     factor;
        int unsigned     steps;
        longint unsigned fib_lo;
        longint unsigned fib_hi;
        longint unsigned fib_nx;
        logic [DATA_BITS-1:0] a;
        logic [DATA_BITS-1:0] b;
        pick = $urandom_range(0, 99);
        a = DATA_BITS'($urandom);
        b = DATA_BITS'($urandom);
        if (pick < 25)
        begin
            // common factor of random size
            gbits  = $urandom_range(1, 30);
            factor = $urandom_range(1, (32'd1 << gbits) - 1);
            a = DATA_BITS'(factor * $urandom_range(0, OPERAND_MAX / factor));
            b = DATA_BITS'(factor * $urandom_range(0, OPERAND_MAX / factor));
        end
        else if (pick < 40)
        begin
            a = DATA_BITS'($urandom_range(0, 64));
            b = DATA_BITS'($urandom_range(0, 64));
        end
        else if (pick < 50)
        begin
            a = DATA_BITS'($urandom_range(1, 16'hFFFF) << $urandom_range(0, 15));
            b = DATA_BITS'($urandom_range(1, 16'hFFFF) << $urandom_range(0, 15));
        end
        else if (pick < 60)
        begin
            // consecutive Fibonacci numbers: longest remainder chains
            steps  = $urandom_range(1, 45);
            fib_lo = 0;
            fib_hi = 1;
            repeat (steps)
            begin
                fib_nx = fib_lo + fib_hi;
                fib_lo = fib_hi;
                fib_hi = fib_nx;
            end
            a = DATA_BITS'(fib_hi);
            b = DATA_BITS'(fib_lo);
            if ($urandom_range(0, 1))
            begin
                a = DATA_BITS'(fib_lo);
                b = DATA_BITS'(fib_hi);
            end
        end
        else if (pick < 65)
        begin
            case ($urandom_range(0, 2))
                0: a = '0;
                1: b = '0;
                default:
                begin
                    a = '0;
                    b = '0;
                end
            endcase
        end
        else if (pick < 70)
        begin
            case ($urandom_range(0, 3))
                0: a = OPERAND_MAX;
                1: a = OPERAND_MAX - 1;
                2: a = 1;
                default: a = b;
            endcase
        end
        return pack_request(a, b);
    endfunction

    // Present one request and wait for it to be taken
    task automatic send_request(input in_t req);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do
            @(posedge clk);
        while (!in_ready);
        results.note_request(req);
    endtask

    task automatic send_pair(input logic [DATA_BITS-1:0] a, input logic [DATA_BITS-1:0] b);
        send_request(pack_request(a, b));
    endtask

    // Hold off new requests until every outstanding result is back
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (results.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        results = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero operands, extremes, equal values, shared factors
        send_pair('0, '0);
        send_pair('0, 1);
        send_pair(1, '0);
        send_pair('0, OPERAND_MAX);
        send_pair(OPERAND_MAX, '0);
        send_pair('0, 7);
        send_pair(1, 1);
        send_pair(1, 2);
        send_pair(OPERAND_MAX, OPERAND_MAX);
        send_pair(OPERAND_MAX, 1);
        send_pair(1, OPERAND_MAX);
        send_pair(OPERAND_MAX, OPERAND_MAX - 1);
        send_pair(31'h4000_0000, 31'h2000_0000);
        send_pair(31'h4000_0000, 31'h4000_0000);
        send_pair(31'h4000_0000, 3);
        send_pair(31'h5555_5555, 31'h2AAA_AAAA);
        send_pair(12, 18);
        send_pair(17, 17);
        send_pair(6, 35);
        send_pair(65536, 98304);
        send_pair(1836311903, 1134903170);
        send_pair(2147483629, 2147483587);
        wait_for_results();

        // Random, across the idle/stall mixes
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 52;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 52;
                end
                default:
                begin
                    send_idle_pct  = 37;
                    recv_stall_pct = 37;
                end
            endcase
            repeat (RANDOM_ITEMS / PHASE_COUNT)
                send_request(make_random_request());
            wait_for_results();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (results.error_count == 0 && results.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
